// ===== rtl/vertex_perspective_projection_assert.svh =====
// assertion macros shared by the projection rtl
// expects signals named clock and reset in the module that uses them
`ifndef VERTEX_PERSPECTIVE_PROJECTION_ASSERT_SVH
`define VERTEX_PERSPECTIVE_PROJECTION_ASSERT_SVH

// same-cycle implication, off while reset is high
`define VPP_ASSERT_IMPLY(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// implication that may also look back past reset
`define VPP_ASSERT_ALWAYS(label, cond, expr, msg) \
   label: assert property (@(posedge clock) (cond) |-> (expr)) \
      else $error(msg);

`endif

// ===== rtl/vpp_pkg.sv =====
// shared types, constants and helper functions for the projection pipeline
// no dependencies
package vpp_pkg;

   localparam int COORD_BITS     = 16;
   localparam int COEF_FRAC_BITS = 8;
   localparam int COEF_BITS      = 16;
   localparam int COEF_COUNT     = 4;
   localparam int CFG_BITS       = COEF_BITS * COEF_COUNT;
   localparam int SCALE_BITS     = 10;
   localparam int CSR_INDEX_BITS = 3;
   localparam int PROD_BITS      = COORD_BITS + COEF_BITS;
   localparam int DOT_BITS       = PROD_BITS + 2;
   localparam int NUM_BITS       = COORD_BITS + COEF_FRAC_BITS;
   localparam int DIV_STEP       = 4;
   localparam int DIV_STAGES     = (NUM_BITS + DIV_STEP - 1) / DIV_STEP;
   localparam int QUO_BITS       = DIV_STAGES * DIV_STEP;
   localparam int VIEW_BITS      = COORD_BITS + SCALE_BITS + 1;
   localparam int COORD_MAX      = 2 ** (COORD_BITS - 1) - 1;
   localparam int COORD_MIN      = -(2 ** (COORD_BITS - 1));
   // dot stages + divider prep + divider + finish + viewport multiply + saturate
   localparam int PIPE_LATENCY   = 2 + 1 + DIV_STAGES + 1 + 2;

   localparam logic [CFG_BITS-1:0]   COEF_X_RESET = CFG_BITS'(160);
   localparam logic [CFG_BITS-1:0]   COEF_Y_RESET = CFG_BITS'(1) << (COEF_BITS + COEF_FRAC_BITS);
   localparam logic [CFG_BITS-1:0]   COEF_Z_RESET =
      CFG_BITS'(1) << (2 * COEF_BITS + COEF_FRAC_BITS);
   localparam logic [CFG_BITS-1:0]   COEF_W_RESET = '0;
   localparam logic [SCALE_BITS-1:0] HALF_W_RESET = SCALE_BITS'(160);
   localparam logic [SCALE_BITS-1:0] HALF_H_RESET = SCALE_BITS'(100);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COEF_X = 3'd0,
      CSR_COEF_Y = 3'd1,
      CSR_COEF_Z = 3'd2,
      CSR_COEF_W = 3'd3,
      CSR_HALF_W = 3'd4,
      CSR_HALF_H = 3'd5
   } csr_index_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DOT_BITS-1:0]   dot_type;

   typedef struct packed {
      coord_type vert_x;
      coord_type vert_y;
      coord_type vert_z;
   } in_type;

   typedef struct packed {
      coord_type screen_x;
      coord_type screen_y;
      coord_type depth;
      logic      w_was_zero;
   } out_type;

   typedef struct packed {
      logic [CFG_BITS-1:0]   coef_x;
      logic [CFG_BITS-1:0]   coef_y;
      logic [CFG_BITS-1:0]   coef_z;
      logic [CFG_BITS-1:0]   coef_w;
      logic [SCALE_BITS-1:0] half_width;
      logic [SCALE_BITS-1:0] half_height;
   } csr_type;

   typedef struct packed {
      logic [DOT_BITS-1:0] rem;
      logic [QUO_BITS-1:0] num;
      logic [QUO_BITS-1:0] quo;
   } div_lane_type;

   // one restoring divide step, numerator bits shift out msb first
   function automatic div_lane_type div_step(div_lane_type l, logic [DOT_BITS-1:0] d);
      logic [DOT_BITS:0] r;
      div_lane_type      o;
      r     = {l.rem, l.num[QUO_BITS-1]};
      o.num = {l.num[QUO_BITS-2:0], 1'b0};
      if (r >= {1'b0, d}) begin
         o.rem = DOT_BITS'(r - {1'b0, d});
         o.quo = {l.quo[QUO_BITS-2:0], 1'b1};
      end else begin
         o.rem = r[DOT_BITS-1:0];
         o.quo = {l.quo[QUO_BITS-2:0], 1'b0};
      end
      return o;
   endfunction

   // fixed point sum to integer, truncating toward zero, then saturate
   function automatic coord_type to_coord(dot_type v);
      dot_type b;
      dot_type s;
      b = v + (v[DOT_BITS-1] ? dot_type'(2 ** COEF_FRAC_BITS - 1) : dot_type'(0));
      s = b >>> COEF_FRAC_BITS;
      if (s > dot_type'(COORD_MAX)) begin
         return coord_type'(COORD_MAX);
      end else if (s < dot_type'(COORD_MIN)) begin
         return coord_type'(COORD_MIN);
      end
      return coord_type'(s);
   endfunction

endpackage

// ===== rtl/vpp_dot.sv =====
// four dot products of the vertex with the coefficient rows, two stages
// depends on vpp_pkg
module vpp_dot
   import vpp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  in_type  vert,
   input  csr_type csr,
   output logic    dot_valid,
   output dot_type dot [COEF_COUNT]
);

   logic signed [PROD_BITS-1:0] prod_ff [COEF_COUNT][COEF_COUNT-1];
   logic signed [PROD_BITS-1:0] prod_in [COEF_COUNT][COEF_COUNT-1];
   coord_type                   konst_ff [COEF_COUNT];
   coord_type                   konst_in [COEF_COUNT];
   logic                        prod_valid_ff;
   dot_type                     dot_ff [COEF_COUNT];
   dot_type                     dot_in [COEF_COUNT];
   logic                        dot_valid_ff;

   always_comb begin
      logic [CFG_BITS-1:0] rows [COEF_COUNT];
      coord_type           v [COEF_COUNT-1];
      rows[0] = csr.coef_x;
      rows[1] = csr.coef_y;
      rows[2] = csr.coef_z;
      rows[3] = csr.coef_w;
      v[0]    = vert.vert_x;
      v[1]    = vert.vert_y;
      v[2]    = vert.vert_z;
      for (int r = 0; r < COEF_COUNT; r++) begin
         for (int c = 0; c < COEF_COUNT - 1; c++) begin
            prod_in[r][c] = v[c] * $signed(rows[r][c*COEF_BITS +: COEF_BITS]);
         end
         konst_in[r] = $signed(rows[r][(COEF_COUNT-1)*COEF_BITS +: COEF_BITS]);
      end
   end

   always_comb begin
      for (int r = 0; r < COEF_COUNT; r++) begin
         dot_in[r] = DOT_BITS'(prod_ff[r][0]) + DOT_BITS'(prod_ff[r][1])
                   + DOT_BITS'(prod_ff[r][2]) + DOT_BITS'(konst_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         dot_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= in_valid;
         dot_valid_ff  <= prod_valid_ff;
      end
      prod_ff  <= prod_in;
      konst_ff <= konst_in;
      dot_ff   <= dot_in;
   end

   assign dot_valid = dot_valid_ff;
   assign dot       = dot_ff;

endmodule

// ===== rtl/vpp_div.sv =====
// truncation, pipelined perspective divide of x, y, z by w and the +1 of x and y
// depends on vpp_pkg
module vpp_div
   import vpp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      dot_valid,
   input  dot_type   dot [COEF_COUNT],
   output logic      res_valid,
   output coord_type res_x_inc,
   output coord_type res_y_inc,
   output coord_type res_z,
   output logic      res_wz
);

   localparam int LANES = COEF_COUNT - 1;

   logic                valid_ff [DIV_STAGES+1];
   div_lane_type        lane_ff  [DIV_STAGES+1][LANES];
   div_lane_type        lane0_in [LANES];
   div_lane_type        lane_in  [1:DIV_STAGES][LANES];
   logic [DOT_BITS-1:0] dmag_ff  [DIV_STAGES+1];
   logic [DOT_BITS-1:0] dmag_in;
   logic                neg_ff   [DIV_STAGES+1][LANES];
   logic                neg_in   [LANES];
   coord_type           pass_ff  [DIV_STAGES+1][LANES];
   coord_type           pass_in  [LANES];
   logic                wz_ff    [DIV_STAGES+1];
   logic                wz_in;
   logic                out_valid_ff;
   coord_type           x_inc_ff, x_inc_in;
   coord_type           y_inc_ff, y_inc_in;
   coord_type           z_ff, z_in;
   logic                out_wz_ff;

   // prep: truncate sums, split into magnitudes and signs
   always_comb begin
      dot_type                w;
      logic [COORD_BITS:0]    mag;
      w       = dot[LANES];
      wz_in   = (w == '0);
      dmag_in = w[DOT_BITS-1] ? DOT_BITS'(-w) : DOT_BITS'(w);
      for (int l = 0; l < LANES; l++) begin
         pass_in[l] = to_coord(dot[l]);
         mag        = pass_in[l][COORD_BITS-1] ? (COORD_BITS+1)'(0) - {1'b1, pass_in[l]}
                                                 : {1'b0, pass_in[l]};
         neg_in[l]  = pass_in[l][COORD_BITS-1] ^ w[DOT_BITS-1];
         lane0_in[l].rem = '0;
         lane0_in[l].quo = '0;
         lane0_in[l].num = QUO_BITS'({mag, {COEF_FRAC_BITS{1'b0}}});
      end
   end

   // DIV_STEP quotient bits per stage
   always_comb begin
      div_lane_type t;
      for (int s = 1; s <= DIV_STAGES; s++) begin
         for (int l = 0; l < LANES; l++) begin
            t = lane_ff[s-1][l];
            for (int k = 0; k < DIV_STEP; k++) begin
               t = div_step(t, dmag_ff[s-1]);
            end
            lane_in[s][l] = t;
         end
      end
   end

   // finish: sign, saturate, zero-w bypass, +1 on x and y
   always_comb begin
      coord_type q [LANES];
      for (int l = 0; l < LANES; l++) begin
         if (wz_ff[DIV_STAGES]) begin
            q[l] = pass_ff[DIV_STAGES][l];
         end else if (neg_ff[DIV_STAGES][l]) begin
            if (lane_ff[DIV_STAGES][l].quo > QUO_BITS'(-COORD_MIN)) begin
               q[l] = coord_type'(COORD_MIN);
            end else begin
               q[l] = coord_type'(QUO_BITS'(0) - lane_ff[DIV_STAGES][l].quo);
            end
         end else begin
            if (lane_ff[DIV_STAGES][l].quo > QUO_BITS'(COORD_MAX)) begin
               q[l] = coord_type'(COORD_MAX);
            end else begin
               q[l] = coord_type'(lane_ff[DIV_STAGES][l].quo);
            end
         end
      end
      x_inc_in = (q[0] == coord_type'(COORD_MAX)) ? q[0] : q[0] + coord_type'(1);
      y_inc_in = (q[1] == coord_type'(COORD_MAX)) ? q[1] : q[1] + coord_type'(1);
      z_in     = q[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff[0] <= dot_valid;
         for (int s = 1; s <= DIV_STAGES; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         out_valid_ff <= valid_ff[DIV_STAGES];
      end
      lane_ff[0] <= lane0_in;
      dmag_ff[0] <= dmag_in;
      neg_ff[0]  <= neg_in;
      pass_ff[0] <= pass_in;
      wz_ff[0]   <= wz_in;
      for (int s = 1; s <= DIV_STAGES; s++) begin
         lane_ff[s] <= lane_in[s];
         dmag_ff[s] <= dmag_ff[s-1];
         neg_ff[s]  <= neg_ff[s-1];
         pass_ff[s] <= pass_ff[s-1];
         wz_ff[s]   <= wz_ff[s-1];
      end
      x_inc_ff  <= x_inc_in;
      y_inc_ff  <= y_inc_in;
      z_ff      <= z_in;
      out_wz_ff <= wz_ff[DIV_STAGES];
   end

   assign res_valid = out_valid_ff;
   assign res_x_inc = x_inc_ff;
   assign res_y_inc = y_inc_ff;
   assign res_z     = z_ff;
   assign res_wz    = out_wz_ff;

endmodule

// ===== rtl/vpp_view.sv =====
// viewport scaling of x and y with saturation, two stages
// depends on vpp_pkg
module vpp_view
   import vpp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      res_valid,
   input  coord_type res_x_inc,
   input  coord_type res_y_inc,
   input  coord_type res_z,
   input  logic      res_wz,
   input  csr_type   csr,
   output logic      out_valid,
   output out_type   out_data
);

   typedef logic signed [VIEW_BITS-1:0] view_type;

   logic      mul_valid_ff;
   view_type  sx_ff, sx_in;
   view_type  sy_ff, sy_in;
   coord_type z_ff;
   logic      wz_ff;
   logic      out_valid_ff;
   out_type   out_ff, out_in;

   function automatic coord_type sat_view(view_type v);
      if (v > view_type'(COORD_MAX)) begin
         return coord_type'(COORD_MAX);
      end else if (v < view_type'(COORD_MIN)) begin
         return coord_type'(COORD_MIN);
      end
      return coord_type'(v);
   endfunction

   always_comb begin
      sx_in = view_type'(res_x_inc) * view_type'({1'b0, csr.half_width});
      sy_in = view_type'(res_y_inc) * view_type'({1'b0, csr.half_height});
   end

   always_comb begin
      out_in.screen_x   = sat_view(sx_ff);
      out_in.screen_y   = sat_view(sy_ff);
      out_in.depth      = z_ff;
      out_in.w_was_zero = wz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= res_valid;
         out_valid_ff <= mul_valid_ff;
      end
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
      z_ff   <= res_z;
      wz_ff  <= res_wz;
      out_ff <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

// ===== rtl/vertex_perspective_projection.sv =====
// Projects one vertex through a 4x4 Q8.8 matrix, divides by w and maps to the
// viewport. A vertex is taken in every cycle in which start is high (busy is
// low except in reset), and its result appears on rsp_strobe/rsp_data after
// these registered steps in order: multiply and sum, truncation, the divider
// that resolves four quotient bits per stage, the finish of the quotient,
// and the viewport multiply and saturation. Results cannot be held off.
// Write csr registers only when no transaction is in flight.
// depends on vpp_pkg, vpp_dot, vpp_div, vpp_view and the assertion header
`include "vertex_perspective_projection_assert.svh"

module vertex_perspective_projection
   import vpp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  in_type                    req_data,
   output logic                      rsp_strobe,
   output out_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata
);

   csr_type   csr_ff, csr_in;
   logic      accept;
   logic      dot_valid;
   dot_type   dot [COEF_COUNT];
   logic      res_valid;
   coord_type res_x_inc;
   coord_type res_y_inc;
   coord_type res_z;
   logic      res_wz;

   assign busy      = reset;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COEF_X: csr_in.coef_x      = csr_wdata;
            CSR_COEF_Y: csr_in.coef_y      = csr_wdata;
            CSR_COEF_Z: csr_in.coef_z      = csr_wdata;
            CSR_COEF_W: csr_in.coef_w      = csr_wdata;
            CSR_HALF_W: csr_in.half_width  = csr_wdata[SCALE_BITS-1:0];
            CSR_HALF_H: csr_in.half_height = csr_wdata[SCALE_BITS-1:0];
            default:    csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.coef_x      <= COEF_X_RESET;
         csr_ff.coef_y      <= COEF_Y_RESET;
         csr_ff.coef_z      <= COEF_Z_RESET;
         csr_ff.coef_w      <= COEF_W_RESET;
         csr_ff.half_width  <= HALF_W_RESET;
         csr_ff.half_height <= HALF_H_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   vpp_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .vert      (req_data),
      .csr       (csr_ff),
      .dot_valid (dot_valid),
      .dot       (dot)
   );

   vpp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .dot_valid (dot_valid),
      .dot       (dot),
      .res_valid (res_valid),
      .res_x_inc (res_x_inc),
      .res_y_inc (res_y_inc),
      .res_z     (res_z),
      .res_wz    (res_wz)
   );

   vpp_view u_view (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_x_inc (res_x_inc),
      .res_y_inc (res_y_inc),
      .res_z     (res_z),
      .res_wz    (res_wz),
      .csr       (csr_ff),
      .out_valid (rsp_strobe),
      .out_data  (rsp_data)
   );

   // every transaction comes out after the fixed latency
   `VPP_ASSERT_IMPLY(a_fwd_latency, accept, ##PIPE_LATENCY rsp_strobe, "result missing")
   // no result without a transaction that latency ago
   `VPP_ASSERT_IMPLY(a_back_latency, rsp_strobe, $past(accept, PIPE_LATENCY), "spurious result")
   // pipeline is empty right after reset
   `VPP_ASSERT_ALWAYS(a_reset_empty, $fell(reset), !rsp_strobe, "result right after reset")

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for vertex_perspective_projection: a directed table, then
// random vertices under changing matrix and viewport settings, checked by a predictor
// depends on vpp_pkg and the projection rtl
module tb_top;
   import vpp_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_HI = 3'd7;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = PIPE_LATENCY + 4;

   typedef struct {
      bit                        is_write;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CFG_BITS-1:0]       wdata;
      in_type                    vert;
      bit                        typed;
      out_type                   want;
   } row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   in_type                    req_data = '0;
   logic                      rsp_strobe;
   out_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]       csr_wdata = '0;

   // predictor copy of the registers
   logic [CFG_BITS-1:0]   mat_x = COEF_X_RESET;
   logic [CFG_BITS-1:0]   mat_y = COEF_Y_RESET;
   logic [CFG_BITS-1:0]   mat_z = COEF_Z_RESET;
   logic [CFG_BITS-1:0]   mat_w = COEF_W_RESET;
   logic [SCALE_BITS-1:0] view_hw = HALF_W_RESET;
   logic [SCALE_BITS-1:0] view_hh = HALF_H_RESET;

   out_type  pending_screen[$];
   int       errors = 0;
   int       stall_count = 0;
   int       idle_pct = 0;
   row_type  directed[$];

   vertex_perspective_projection uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint clamp(longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   function automatic longint matrix_row(logic [CFG_BITS-1:0] m, in_type v);
      longint c[4];
      for (int k = 0; k < 4; k++) c[k] = longint'($signed(m[16*k +: 16]));
      return longint'(v.vert_x) * c[0] + longint'(v.vert_y) * c[1]
           + longint'(v.vert_z) * c[2] + c[3];
   endfunction

   function automatic out_type project_vertex(in_type v);
      longint  px, py, pz, w;
      out_type o;
      px = clamp(matrix_row(mat_x, v) / 256);
      py = clamp(matrix_row(mat_y, v) / 256);
      pz = clamp(matrix_row(mat_z, v) / 256);
      w  = matrix_row(mat_w, v);
      if (w != 0) begin
         px = clamp(px * 256 / w);
         py = clamp(py * 256 / w);
         pz = clamp(pz * 256 / w);
      end
      o.screen_x   = coord_type'(clamp(clamp(px + 1) * longint'(view_hw)));
      o.screen_y   = coord_type'(clamp(clamp(py + 1) * longint'(view_hh)));
      o.depth      = coord_type'(pz);
      o.w_was_zero = (w == 0);
      return o;
   endfunction

   function automatic in_type vtx(int x, int y, int z);
      in_type v;
      v.vert_x = coord_type'(x);
      v.vert_y = coord_type'(y);
      v.vert_z = coord_type'(z);
      return v;
   endfunction

   function automatic out_type scr(int sx, int sy, int d, bit wz);
      out_type o;
      o.screen_x = coord_type'(sx);
      o.screen_y = coord_type'(sy);
      o.depth = coord_type'(d);
      o.w_was_zero = wz;
      return o;
   endfunction

   function automatic logic [CFG_BITS-1:0] quad(int c0, int c1, int c2, int c3);
      return {16'(c3), 16'(c2), 16'(c1), 16'(c0)};
   endfunction

   function automatic void add_item(in_type v, bit typed = 0, out_type want = '0);
      row_type r;
      r.is_write = 0;
      r.index = '0;
      r.wdata = '0;
      r.vert = v;
      r.typed = typed;
      r.want = want;
      directed.push_back(r);
   endfunction

   function automatic void add_write(logic [CSR_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] d);
      row_type r;
      r.is_write = 1;
      r.index = idx;
      r.wdata = d;
      r.vert = '0;
      r.typed = 0;
      r.want = '0;
      directed.push_back(r);
   endfunction

   function automatic logic [15:0] rand_coef();
      case ($urandom_range(5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'($urandom);
         default: return 16'(int'($urandom_range(1024)) - 512);
      endcase
   endfunction

   function automatic logic [CFG_BITS-1:0] rand_matrix_row(bit may_clear);
      logic [CFG_BITS-1:0] m;
      if (may_clear && $urandom_range(3) == 0) return '0;
      if ($urandom_range(5) == 0) return {$urandom, $urandom};
      for (int k = 0; k < 4; k++) m[16*k +: 16] = rand_coef();
      return m;
   endfunction

   function automatic logic [CFG_BITS-1:0] rand_scale();
      logic [CFG_BITS-1:0] hi_junk;
      hi_junk = {$urandom, $urandom} & ~64'h3FF;
      case ($urandom_range(3))
         0: return hi_junk | 64'd0;
         1: return hi_junk | 64'd1023;
         default: return hi_junk | 64'($urandom_range(1023));
      endcase
   endfunction

   function automatic coord_type rand_coord(int mode);
      case (mode)
         0: return coord_type'(int'($urandom_range(600)) - 300);
         1: return coord_type'($urandom);
         default: begin
            case ($urandom_range(4))
               0: return coord_type'(COORD_MAX);
               1: return coord_type'(COORD_MIN);
               2: return coord_type'(0);
               3: return coord_type'(-1);
               default: return coord_type'($urandom);
            endcase
         end
      endcase
   endfunction

   task automatic send_vertex(in_type v, bit typed, out_type want);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= v;
      do @(posedge clock); while (busy);
      pending_screen.push_back(typed ? want : project_vertex(v));
   endtask

   // stop the vertex stream and let the pipeline empty
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_screen.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] d);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_COEF_X: mat_x = d;
         CSR_COEF_Y: mat_y = d;
         CSR_COEF_Z: mat_z = d;
         CSR_COEF_W: mat_w = d;
         CSR_HALF_W: view_hw = d[SCALE_BITS-1:0];
         CSR_HALF_H: view_hh = d[SCALE_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      out_type want;
      if (!reset && rsp_strobe) begin
         if (pending_screen.size() == 0) begin
            $error("result transaction with nothing expected");
            errors++;
         end else begin
            want = pending_screen.pop_front();
            if (rsp_data.screen_x !== want.screen_x) begin
               $error("screen_x expected %0d got %0d", want.screen_x, rsp_data.screen_x);
               errors++;
            end
            if (rsp_data.screen_y !== want.screen_y) begin
               $error("screen_y expected %0d got %0d", want.screen_y, rsp_data.screen_y);
               errors++;
            end
            if (rsp_data.depth !== want.depth) begin
               $error("depth expected %0d got %0d", want.depth, rsp_data.depth);
               errors++;
            end
            if (rsp_data.w_was_zero !== want.w_was_zero) begin
               $error("w_was_zero expected %0d got %0d", want.w_was_zero,
                  rsp_data.w_was_zero);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction of any kind
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   initial begin
      int idle_plan[3];
      in_type v;
      int mode;
      idle_plan = '{31, 48, 0};

      // reset matrix: w row is zero, so every result flags it
      add_item(vtx(0, 0, 0), 1, scr(160, 100, 0, 1));
      add_item(vtx(32767, 32767, 32767), 1, scr(32767, 32767, 32767, 1));
      add_item(vtx(-32768, -32768, -32768), 1, scr(-32768, -32768, -32768, 1));
      add_item(vtx(-1, -1, -1), 1, scr(160, 0, -1, 1));
      add_item(vtx(100, -50, 7));
      // w of exactly 1.0
      add_write(CSR_COEF_W, quad(0, 0, 0, 256));
      add_item(vtx(10, 20, 30));
      add_item(vtx(-10, 5, -7));
      // tiny w drives the quotient into saturation
      add_write(CSR_COEF_W, quad(0, 0, 0, 1));
      add_item(vtx(32767, 32767, 32767));
      add_item(vtx(-32768, -32768, -32768));
      add_item(vtx(3, -4, 5));
      // w is the negative of x, zero only when x is zero
      add_write(CSR_COEF_W, quad(-256, 0, 0, 0));
      add_item(vtx(0, 5, 5));
      add_item(vtx(3, 5, -5));
      add_item(vtx(-3, -5, 5));
      // viewport extremes, junk above the 10 bits is dropped
      add_write(CSR_HALF_W, 64'hFFFF_F000_0000_07FF);
      add_write(CSR_HALF_H, 64'hAAAA_5555_0000_0400);
      add_item(vtx(7, 7, 7));
      add_item(vtx(-2, 9, 1));
      // extreme coefficients
      add_write(CSR_COEF_X, quad(-32768, -32768, -32768, -32768));
      add_write(CSR_COEF_Y, quad(32767, 32767, 32767, 32767));
      add_write(CSR_COEF_Z, quad(32767, -32768, 0, -1));
      add_item(vtx(32767, -32768, 1));
      add_item(vtx(-32768, 32767, -1));
      // unused register indexes leave everything alone
      add_write(CSR_UNUSED_LO, {64{1'b1}});
      add_write(CSR_UNUSED_HI, 64'h1234_5678_9ABC_DEF0);
      add_item(vtx(12, -34, 56));
      add_write(CSR_COEF_W, '0);
      add_item(vtx(-32768, 0, 32767));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_pct = 20;
      foreach (directed[i]) begin
         if (directed[i].is_write) begin
            drain();
            write_csr(directed[i].index, directed[i].wdata);
         end else begin
            send_vertex(directed[i].vert, directed[i].typed, directed[i].want);
         end
      end

      for (int p = 0; p < 3; p++) begin
         idle_pct = idle_plan[p];
         for (int seg = 0; seg < 6; seg++) begin
            drain();
            write_csr(CSR_COEF_X, rand_matrix_row(0));
            write_csr(CSR_COEF_Y, rand_matrix_row(0));
            write_csr(CSR_COEF_Z, rand_matrix_row(0));
            write_csr(CSR_COEF_W, rand_matrix_row(1));
            write_csr(CSR_HALF_W, rand_scale());
            write_csr(CSR_HALF_H, rand_scale());
            if ($urandom_range(3) == 0)
               write_csr($urandom_range(1) ? CSR_UNUSED_LO : CSR_UNUSED_HI, {$urandom, $urandom});
            for (int n = 0; n < 88; n++) begin
               mode = $urandom_range(2);
               v.vert_x = rand_coord(mode);
               v.vert_y = rand_coord(mode);
               v.vert_z = rand_coord(mode);
               send_vertex(v, 0, '0);
            end
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
